// File: src/cvm_pkg.sv
// Shared types, widths, rounding helpers and the back-end step table of the view matrix block.
package cvm_pkg;

  // Fraction bits of every fixed-point value
  localparam int FRAC_BITS = 16;

  // Widths of the internal vectors
  localparam int UNIT_W = FRAC_BITS + 2;   // unit vector component, |v| <= 1.0
  localparam int L_W    = FRAC_BITS + 3;   // left axis component
  localparam int T_W    = FRAC_BITS + 4;   // true up component, widest multiplier operand
  localparam int MAG_W  = 33;              // magnitude of a 33-bit signed difference
  localparam int NUM_W  = FRAC_BITS + 32;  // dividend of the unit vector division
  localparam int ACC_W  = FRAC_BITS + 37;  // product accumulator
  localparam int RND_W  = ACC_W - FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(FRAC_BITS + 1);
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(21);

  typedef logic signed [31:0]       s32_t;
  typedef logic signed [32:0]       s33_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [L_W-1:0]    left_t;
  typedef logic signed [T_W-1:0]    tup_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  // One request on the input side
  typedef struct packed {
    s32_t eye_x;
    s32_t eye_y;
    s32_t eye_z;
    s32_t target_x;
    s32_t target_y;
    s32_t target_z;
    s32_t up_x;
    s32_t up_y;
    s32_t up_z;
  } in_t;

  // One matrix row on the result side
  typedef struct packed {
    logic [1:0] row_index;
    s32_t       col0;
    s32_t       col1;
    s32_t       col2;
    s32_t       col3;
    logic       degenerate;
    logic       last_row;
  } out_t;

  // Classified request held between front and back
  typedef struct packed {
    s32_t [2:0] eye;
    s33_t [2:0] d;
    s33_t [2:0] up;
    logic       degen;
  } item_t;

  // Normalize unit handshake
  typedef struct packed {
    logic       start;
    s33_t [2:0] vec;
  } norm_req_t;

  typedef struct packed {
    logic        done;
    unit_t [2:0] unit;
  } norm_rsp_t;

  // Back-end step table codes
  typedef enum logic [3:0] {
    OPA_F0, OPA_F1, OPA_F2, OPA_L0, OPA_L1, OPA_L2, OPA_T0, OPA_T1, OPA_T2
  } opa_t;

  typedef enum logic [3:0] {
    OPB_N0, OPB_N1, OPB_N2, OPB_F0, OPB_F1, OPB_F2, OPB_E0, OPB_E1, OPB_E2
  } opb_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_L0, ST_L1, ST_L2, ST_T0, ST_T1, ST_T2
  } store_t;

  typedef enum logic [1:0] {
    EM_NONE, EM_ROW0, EM_ROW1, EM_ROW2
  } emit_t;

  typedef struct packed {
    opa_t   a;
    opb_t   b;
    logic   first;
    logic   sub;
    store_t st;
    emit_t  em;
  } ucode_t;

  // Step table: one multiply-accumulate per step; a step that opens a new sum
  // also stores or emits the sum that the accumulator holds from the last one.
  // Left and true up dot sums are accumulated negated so each translation is a plain rounding.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t u;
    unique case (step)
      5'd0:  u = '{OPA_F1, OPB_N2, 1'b1, 1'b0, ST_NONE, EM_NONE};
      5'd1:  u = '{OPA_F2, OPB_N1, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd2:  u = '{OPA_F2, OPB_N0, 1'b1, 1'b0, ST_L0,   EM_NONE};
      5'd3:  u = '{OPA_F0, OPB_N2, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd4:  u = '{OPA_F0, OPB_N1, 1'b1, 1'b0, ST_L1,   EM_NONE};
      5'd5:  u = '{OPA_F1, OPB_N0, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd6:  u = '{OPA_L1, OPB_F2, 1'b1, 1'b0, ST_L2,   EM_NONE};
      5'd7:  u = '{OPA_L2, OPB_F1, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd8:  u = '{OPA_L2, OPB_F0, 1'b1, 1'b0, ST_T0,   EM_NONE};
      5'd9:  u = '{OPA_L0, OPB_F2, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd10: u = '{OPA_L0, OPB_F1, 1'b1, 1'b0, ST_T1,   EM_NONE};
      5'd11: u = '{OPA_L1, OPB_F0, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd12: u = '{OPA_L0, OPB_E0, 1'b1, 1'b1, ST_T2,   EM_NONE};
      5'd13: u = '{OPA_L1, OPB_E1, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd14: u = '{OPA_L2, OPB_E2, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd15: u = '{OPA_T0, OPB_E0, 1'b1, 1'b1, ST_NONE, EM_ROW0};
      5'd16: u = '{OPA_T1, OPB_E1, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd17: u = '{OPA_T2, OPB_E2, 1'b0, 1'b1, ST_NONE, EM_NONE};
      5'd18: u = '{OPA_F0, OPB_E0, 1'b1, 1'b0, ST_NONE, EM_ROW1};
      5'd19: u = '{OPA_F1, OPB_E1, 1'b0, 1'b0, ST_NONE, EM_NONE};
      5'd20: u = '{OPA_F2, OPB_E2, 1'b0, 1'b0, ST_NONE, EM_NONE};
      5'd21: u = '{OPA_F0, OPB_N0, 1'b1, 1'b0, ST_NONE, EM_ROW2};
      default: u = '{OPA_F0, OPB_N0, 1'b1, 1'b0, ST_NONE, EM_NONE};
    endcase
    return u;
  endfunction

  // Shift right by FRAC_BITS, rounding half away from zero
  function automatic rnd_t sround(input acc_t v);
    logic [ACC_W:0] half;
    logic [ACC_W:0] s;
    half = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
    s = {v[ACC_W-1], v} + half - (ACC_W + 1)'(v[ACC_W-1]);
    return rnd_t'(s[ACC_W:FRAC_BITS]);
  endfunction

  // Saturate to the signed 32-bit range
  function automatic s32_t sat32(input rnd_t v);
    s32_t r;
    if (v[RND_W-1:31] == '0 || v[RND_W-1:31] == '1) begin
      r = s32_t'(v[31:0]);
    end else if (v[RND_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// File: src/cvm_front.sv
// Front end: forms the view direction and flags requests with a zero-length vector.
module cvm_front import cvm_pkg::*; (
  input  in_t   item,
  input  logic  push,
  input  logic  q_full,
  output logic  wr,
  output item_t wdata,
  output logic  full
);

  logic d_zero;
  logic up_zero;

  // Take a request whenever the queue has room
  assign full = q_full;
  assign wr   = push && !q_full;

  // Form target minus eye at full width
  always_comb begin
    wdata.eye[0] = item.eye_x;
    wdata.eye[1] = item.eye_y;
    wdata.eye[2] = item.eye_z;
    wdata.d[0]   = 33'(item.target_x) - 33'(item.eye_x);
    wdata.d[1]   = 33'(item.target_y) - 33'(item.eye_y);
    wdata.d[2]   = 33'(item.target_z) - 33'(item.eye_z);
    wdata.up[0]  = 33'(item.up_x);
    wdata.up[1]  = 33'(item.up_y);
    wdata.up[2]  = 33'(item.up_z);
    d_zero       = (item.target_x == item.eye_x) && (item.target_y == item.eye_y) &&
                   (item.target_z == item.eye_z);
    up_zero      = (item.up_x == '0) && (item.up_y == '0) && (item.up_z == '0);
    wdata.degen  = d_zero || up_zero;
  end

endmodule

// File: src/cvm_queue.sv
// Two-entry queue of classified requests between front and back ends.
module cvm_queue import cvm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wdata,
  output logic  full,
  output logic  empty,
  input  logic  rd,
  output item_t rdata
);

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = mem[rptr];

  // Store payload
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      if (wr && !rd) begin
        cnt <= cnt + 2'd1;
      end else if (rd && !wr) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// File: src/cvm_norm.sv
// Normalize unit: scales a vector, takes its length by a bit-serial square root
// and divides each component by it, one quotient bit per cycle.
module cvm_norm import cvm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  output norm_rsp_t rsp
);

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_SQRT  = 7'b0001000,
    N_PREP  = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_DONE  = 7'b1000000
  } nstate_t;

  nstate_t                 state;
  logic [MAG_W-1:0]        mag [3];
  logic [2:0]              neg;
  logic [63:0]             acc;
  logic [1:0]              idx;
  logic [63:0]             rbit;
  logic [63:0]             res;
  logic [NUM_W-1:0]        dsr;
  logic [NUM_W-1:0]        rem [3];
  logic [FRAC_BITS:0]      quo [3];
  logic [DCNT_W-1:0]       dcnt;

  logic [MAG_W-1:0] top;
  logic [30:0]      mag_sel;
  logic [61:0]      sq;
  logic [64:0]      trial;
  logic             ge;
  logic [31:0]      len;
  logic             load;

  assign top     = mag[0] | mag[1] | mag[2];
  assign mag_sel = mag[idx][30:0];
  assign sq      = 62'(mag_sel) * 62'(mag_sel);
  assign trial   = {1'b0, res} + {1'b0, rbit};
  assign ge      = {1'b0, acc} >= trial;
  assign len     = res[31:0];
  assign load    = req.start && (state == N_IDLE || state == N_DONE);

  // Signed unit components from the quotients
  always_comb begin
    rsp.done = (state == N_DONE);
    for (int i = 0; i < 3; i++) begin
      rsp.unit[i] = neg[i] ? -UNIT_W'(quo[i]) : UNIT_W'(quo[i]);
    end
  end

  // Sequence the normalize steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE:  if (load) state <= N_SHIFT;
        N_SHIFT: if (top[32:31] == 2'b00 && top[30]) state <= N_SQ;
        N_SQ:    if (idx == 2'd2) state <= N_SQRT;
        N_SQRT:  if (rbit[0]) state <= N_PREP;
        N_PREP:  state <= N_DIV;
        N_DIV:   if (dcnt == '0) state <= N_DONE;
        N_DONE:  state <= load ? N_SHIFT : N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= req.vec[i][32] ? MAG_W'(-req.vec[i]) : MAG_W'(req.vec[i]);
        neg[i] <= req.vec[i][32];
      end
    end
    unique case (state)
      N_SHIFT: begin
        // Bring the largest magnitude into [2^30, 2^31)
        if (top[32:31] != 2'b00) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end else if (!top[30]) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] << 1;
          end
        end
        acc <= '0;
        idx <= 2'd0;
      end
      N_SQ: begin
        // Accumulate the sum of squares
        acc  <= acc + 64'(sq);
        idx  <= idx + 2'd1;
        res  <= '0;
        rbit <= 64'(1) << 62;
      end
      N_SQRT: begin
        // One root bit per cycle
        if (ge) begin
          acc <= acc - trial[63:0];
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
      end
      N_PREP: begin
        // Load rounded dividends and the aligned divisor
        for (int i = 0; i < 3; i++) begin
          rem[i] <= NUM_W'({mag[i][30:0], FRAC_BITS'(0)}) + NUM_W'(len >> 1);
          quo[i] <= '0;
        end
        dsr  <= {len, FRAC_BITS'(0)};
        dcnt <= DCNT_W'(FRAC_BITS);
      end
      N_DIV: begin
        // One quotient bit per cycle in each lane
        for (int i = 0; i < 3; i++) begin
          if (rem[i] >= dsr) begin
            rem[i] <= rem[i] - dsr;
            quo[i] <= {quo[i][FRAC_BITS-1:0], 1'b1};
          end else begin
            quo[i] <= {quo[i][FRAC_BITS-1:0], 1'b0};
          end
        end
        dsr  <= dsr >> 1;
        dcnt <= dcnt - DCNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/cvm_back.sv
// Back end: for a regular request runs the normalize unit twice, then builds
// the cross products and translations on one MAC unit and sends the rows.
module cvm_back import cvm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  item_t     q_item,
  input  logic      q_empty,
  output logic      q_pop,
  output norm_req_t nreq,
  input  norm_rsp_t nrsp,
  output out_t      result,
  output logic      empty,
  input  logic      pop
);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_NORM_F = 5'b00010,
    B_NORM_N = 5'b00100,
    B_MAC    = 5'b01000,
    B_ZERO   = 5'b10000
  } bstate_t;

  bstate_t           state;
  s32_t  [2:0]       eye;
  s33_t  [2:0]       upv;
  unit_t [2:0]       f;
  unit_t [2:0]       n;
  left_t [2:0]       l;
  tup_t  [2:0]       t;
  acc_t              acc;
  logic [STEP_W-1:0] step;
  logic [1:0]        zrow;
  logic              out_valid;

  ucode_t            uc;
  tup_t              opa;
  s32_t              opb;
  logic signed [T_W+31:0] prod;
  acc_t              acc_next;
  rnd_t              rnd;
  logic              can_emit;
  logic              mac_emit;
  logic              advance;
  logic              zero_emit;
  out_t              row;

  assign uc       = ucode(step);
  assign can_emit = !out_valid || pop;
  assign mac_emit = (state == B_MAC) && (uc.em != EM_NONE);
  assign advance  = (state == B_MAC) && (can_emit || uc.em == EM_NONE);
  assign zero_emit = (state == B_ZERO) && can_emit;
  assign empty    = !out_valid;
  assign q_pop    = (state == B_IDLE) && !q_empty;

  // Start the normalize unit on forward, then on up
  always_comb begin
    nreq.start = ((state == B_IDLE) && !q_empty && !q_item.degen) ||
                 ((state == B_NORM_F) && nrsp.done);
    nreq.vec   = (state == B_IDLE) ? q_item.d : upv;
  end

  // Select multiplier operands
  always_comb begin
    unique case (uc.a)
      OPA_F0:  opa = T_W'(f[0]);
      OPA_F1:  opa = T_W'(f[1]);
      OPA_F2:  opa = T_W'(f[2]);
      OPA_L0:  opa = T_W'(l[0]);
      OPA_L1:  opa = T_W'(l[1]);
      OPA_L2:  opa = T_W'(l[2]);
      OPA_T0:  opa = t[0];
      OPA_T1:  opa = t[1];
      OPA_T2:  opa = t[2];
      default: opa = '0;
    endcase
    unique case (uc.b)
      OPB_N0:  opb = 32'(n[0]);
      OPB_N1:  opb = 32'(n[1]);
      OPB_N2:  opb = 32'(n[2]);
      OPB_F0:  opb = 32'(f[0]);
      OPB_F1:  opb = 32'(f[1]);
      OPB_F2:  opb = 32'(f[2]);
      OPB_E0:  opb = eye[0];
      OPB_E1:  opb = eye[1];
      OPB_E2:  opb = eye[2];
      default: opb = '0;
    endcase
  end

  // Multiply-accumulate and round the finished sum
  assign prod     = opa * opb;
  assign acc_next = (uc.first ? '0 : acc) + (uc.sub ? -ACC_W'(prod) : ACC_W'(prod));
  assign rnd      = sround(acc);

  // Assemble the outgoing row
  always_comb begin
    row.degenerate = 1'b0;
    row.col3       = sat32(rnd);
    row.row_index  = 2'd0;
    row.last_row   = 1'b0;
    row.col0       = 32'(l[0]);
    row.col1       = 32'(l[1]);
    row.col2       = 32'(l[2]);
    if (state == B_ZERO) begin
      row.row_index  = zrow;
      row.col0       = '0;
      row.col1       = '0;
      row.col2       = '0;
      row.col3       = '0;
      row.degenerate = 1'b1;
      row.last_row   = (zrow == 2'd2);
    end else begin
      unique case (uc.em)
        EM_ROW1: begin
          row.row_index = 2'd1;
          row.col0      = 32'(t[0]);
          row.col1      = 32'(t[1]);
          row.col2      = 32'(t[2]);
        end
        EM_ROW2: begin
          row.row_index = 2'd2;
          row.col0      = -(32'(f[0]));
          row.col1      = -(32'(f[1]));
          row.col2      = -(32'(f[2]));
          row.last_row  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequence the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= q_item.degen ? B_ZERO : B_NORM_F;
          end
        end
        B_NORM_F: if (nrsp.done) state <= B_NORM_N;
        B_NORM_N: if (nrsp.done) state <= B_MAC;
        B_MAC:    if (advance && step == STEP_LAST) state <= B_IDLE;
        B_ZERO:   if (zero_emit && zrow == 2'd2) state <= B_IDLE;
        default:  state <= B_IDLE;
      endcase
    end
  end

  // Hold the request and the intermediate vectors
  always_ff @(posedge clk) begin
    if (q_pop) begin
      eye  <= q_item.eye;
      upv  <= q_item.up;
      zrow <= 2'd0;
    end
    if (state == B_NORM_F && nrsp.done) begin
      f <= nrsp.unit;
    end
    if (state == B_NORM_N && nrsp.done) begin
      n    <= nrsp.unit;
      step <= '0;
    end
    if (zero_emit) begin
      zrow <= zrow + 2'd1;
    end
    if (advance) begin
      acc  <= acc_next;
      step <= step + STEP_W'(1);
      case (uc.st)
        ST_L0:   l[0] <= L_W'(rnd);
        ST_L1:   l[1] <= L_W'(rnd);
        ST_L2:   l[2] <= L_W'(rnd);
        ST_T0:   t[0] <= T_W'(rnd);
        ST_T1:   t[1] <= T_W'(rnd);
        ST_T2:   t[2] <= T_W'(rnd);
        default: begin
        end
      endcase
    end
  end

  // Output register: load a row, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((mac_emit && can_emit) || zero_emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((mac_emit && can_emit) || zero_emit) begin
      result <= row;
    end
  end

endmodule

// File: src/camera_view_matrix_top.sv
// Top level of the look-at view matrix block.
// Each request (eye, target, up in signed Q16.16) yields three rows of the view
// matrix, row 0 left, row 1 true up, row 2 negated forward, each with its
// translation in the last column; the last row is marked. A request whose
// forward or up vector has zero length gives three zero rows flagged degenerate,
// one per cycle while the output register is free or popped, and holds the back
// end until the third is sent. For a regular request the one normalize unit,
// shared by both vectors, scales one bit, finds one root bit and one quotient
// bit per cycle, and the 22 cross and dot product steps share one multiplier.
// A two-entry queue takes further requests while the back end works, and an
// output register holds a row until it is popped.
module camera_view_matrix_top import cvm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);

  logic      q_wr;
  item_t     q_wdata;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  item_t     q_rdata;
  norm_req_t nreq;
  norm_rsp_t nrsp;

  cvm_front u_front (
    .item   (item),
    .push   (push),
    .q_full (q_full),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .full   (full)
  );

  cvm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .empty (q_empty),
    .rd    (q_pop),
    .rdata (q_rdata)
  );

  cvm_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .rsp (nrsp)
  );

  cvm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .nreq    (nreq),
    .nrsp    (nrsp),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  // Only row two closes a matrix
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last_row == (result.row_index == 2'd2)))
    else $error("last_row does not match row_index");

  // Degenerate rows carry zeros
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.degenerate) |->
      (result.col0 == '0 && result.col1 == '0 && result.col2 == '0 && result.col3 == '0))
    else $error("degenerate row with nonzero entries");

  // Rows of one matrix follow in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last_row) |=>
      (empty || result.row_index == $past(result.row_index) + 2'd1))
    else $error("rows out of order");

  // The normalize unit is started only while the back end needs it
  a_norm_start: assert property (@(posedge clk) disable iff (rst)
    nreq.start |-> (q_pop || nrsp.done))
    else $error("normalize start outside a request");

endmodule
